// File: design/assert_macros.svh
// Assertion macros used by the top-level design file of the text console.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AST_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/tcw_pkg.sv
// Types and constants of the text console character writer.
// No dependencies; used by the interfaces, the cursor stepper and the top level.
package tcw_pkg;

	// Field widths of the request and response items.
	localparam int OPC_W  = 2;
	localparam int CHR_W  = 8;
	localparam int TGT_W  = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int OFS_W  = 11;
	localparam int CELL_W = 16;

	// Operation codes.
	typedef enum logic [OPC_W-1:0] {
		OP_PUT   = 2'd0,
		OP_MOVE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Control characters.
	localparam logic [CHR_W-1:0] CH_CR = 8'd13;
	localparam logic [CHR_W-1:0] CH_LF = 8'd10;
	localparam logic [CHR_W-1:0] CH_BS = 8'd8;

	// Cell contents.
	localparam logic [CHR_W-1:0]  SPACE_CHAR = 8'h20;
	localparam logic [CHR_W-1:0]  BLANK_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, SPACE_CHAR};

	// Result of stepping the cursor for one put-character operation.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             wr_cell;
		logic             scroll;
	} cursor_step_t;

endpackage

// File: design/tcw_if.sv
// Request and response channel interfaces of the text console character writer.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if import tcw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OPC_W-1:0] operation;
	logic [CHR_W-1:0] char_code;
	logic [TGT_W-1:0] target_column;
	logic [TGT_W-1:0] target_row;

	modport source (output valid, operation, char_code, target_column, target_row,
		input ready);
	modport sink (input valid, operation, char_code, target_column, target_row,
		output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic [OFS_W-1:0]  cursor_offset;
	logic [CELL_W-1:0] cell_value;
	logic              command_ignored;

	modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_value,
		command_ignored, input ready);
	modport sink (input valid, cursor_column, cursor_row, cursor_offset, cell_value,
		command_ignored, output ready);
endinterface

// File: design/tcw_cursor.sv
// Cursor stepper for one put-character operation of the text console.
// Depends on tcw_pkg for the control characters and the step struct.
module tcw_cursor import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] row,
	input  logic [CHR_W-1:0] char_code,
	output cursor_step_t     step
);

	// One wider than the cursor so that the overflow can be seen.
	logic [COL_W:0] ncol;
	logic [ROW_W:0] nrow;
	logic           wr;

	// Character handling followed by line wrap and scroll detection.
	always_comb begin
		ncol = {1'b0, col};
		nrow = {1'b0, row};
		wr   = 1'b0;
		case (char_code)
			CH_CR: begin
				ncol = '0;
			end
			CH_LF: begin
				ncol = '0;
				nrow = nrow + 1'b1;
			end
			CH_BS: begin
				if (col == '0) begin
					if (row != '0) begin
						nrow = nrow - 1'b1;
						ncol = (COL_W+1)'(COLUMNS - 1);
					end
				end else begin
					ncol = ncol - 1'b1;
				end
			end
			default: begin
				wr   = 1'b1;
				ncol = ncol + 1'b1;
			end
		endcase

		if (ncol >= (COL_W+1)'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + 1'b1;
		end

		step.scroll = 1'b0;
		if (nrow >= (ROW_W+1)'(ROWS)) begin
			nrow        = (ROW_W+1)'(ROWS - 1);
			step.scroll = 1'b1;
		end

		step.col     = ncol[COL_W-1:0];
		step.row     = nrow[ROW_W-1:0];
		step.wr_cell = wr;
	end

endmodule

// File: design/text_console_character_writer.sv
// A put, move or read result is loaded into the output register by the execute step after the transfer,
// which waits while the register holds an untaken result; a new request is taken only in the idle state.
// Clear and scrolling puts add a sweep over the store and a drain step: one store entry is swept per cycle.
// Reset: cursor home, attribute 7; a clearing pass then blanks the cell store while no request is taken
// (attribute writes are still accepted).
`include "assert_macros.svh"

module text_console_character_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CHR_W-1:0] cfg_wr_data,
	tcw_req_if.sink          req,
	tcw_rsp_if.source        rsp
);

	localparam int N        = COLUMNS * ROWS;
	localparam int AW       = $clog2(N);
	localparam int CPY_END  = N - COLUMNS;
	localparam int LIN_W    = 12;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration and cursor.
	logic [CHR_W-1:0] attr_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;

	// Latched request.
	logic [OPC_W-1:0] op_q;
	logic [CHR_W-1:0] ch_q;
	logic [TGT_W-1:0] tc_q;
	logic [TGT_W-1:0] tr_q;

	// Sweep control and its write stage.
	logic [AW-1:0]     cnt_q;
	logic              copy_q;
	logic              report_q;
	logic [CELL_W-1:0] fill_q;
	logic              wr_s1;
	logic              cpy_s1;
	logic [AW-1:0]     addr_s1;

	// Result register.
	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [OFS_W-1:0]  out_ofs_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_ign_q;

	// Cell store.
	logic [CELL_W-1:0] mem [N];
	logic [CELL_W-1:0] mem_rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	logic              req_xfer;
	logic              slot_free;
	logic              exec_go;
	logic              load_out;
	logic              on_screen;
	logic              sweep_cpy;
	logic [15:0]       rd_lin;
	logic [LIN_W-1:0]  cur_lin;
	logic [LIN_W-1:0]  ofs_lin;
	logic [COL_W-1:0]  ofs_col;
	logic [ROW_W-1:0]  ofs_row;
	cursor_step_t      step;

	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic [CELL_W-1:0] nxt_cell;
	logic              nxt_ign;
	logic              put_we;
	logic              go_sweep;
	logic              go_clear;

	// Handshake and timing of the result register.
	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign exec_go   = (state_q == S_EXEC) && slot_free;
	assign load_out  = (exec_go && !go_sweep) || (state_q == S_DRAIN && report_q);

	assign rsp.valid           = out_valid_q;
	assign rsp.cursor_column   = out_col_q;
	assign rsp.cursor_row      = out_row_q;
	assign rsp.cursor_offset   = out_ofs_q;
	assign rsp.cell_value      = out_cell_q;
	assign rsp.command_ignored = out_ign_q;

	// Position checks and linear addresses.
	assign on_screen = (tc_q < TGT_W'(COLUMNS)) && (tr_q < TGT_W'(ROWS));
	assign rd_lin    = 16'(req.target_row) * 16'(COLUMNS) + 16'(req.target_column);
	assign cur_lin   = LIN_W'(cur_row_q) * LIN_W'(COLUMNS) + LIN_W'(cur_col_q);
	assign sweep_cpy = copy_q && (cnt_q < AW'(CPY_END));

	tcw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.col       (cur_col_q),
		.row       (cur_row_q),
		.char_code (ch_q),
		.step      (step)
	);

	// Execute step: next cursor, read result and follow-up sweep.
	always_comb begin
		nxt_col  = cur_col_q;
		nxt_row  = cur_row_q;
		nxt_cell = '0;
		nxt_ign  = 1'b0;
		put_we   = 1'b0;
		go_sweep = 1'b0;
		go_clear = 1'b0;
		case (op_t'(op_q))
			OP_PUT: begin
				nxt_col  = step.col;
				nxt_row  = step.row;
				put_we   = step.wr_cell;
				go_sweep = step.scroll;
			end
			OP_MOVE: begin
				if (on_screen) begin
					nxt_col = tc_q[COL_W-1:0];
					nxt_row = tr_q[ROW_W-1:0];
				end else begin
					nxt_ign = 1'b1;
				end
			end
			OP_CLEAR: begin
				nxt_col  = '0;
				nxt_row  = '0;
				go_sweep = 1'b1;
				go_clear = 1'b1;
			end
			OP_READ: begin
				if (on_screen) begin
					nxt_cell = mem_rdata_q;
				end else begin
					nxt_ign = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Cursor offset of the reported position.
	assign ofs_col = (state_q == S_EXEC) ? nxt_col : cur_col_q;
	assign ofs_row = (state_q == S_EXEC) ? nxt_row : cur_row_q;
	assign ofs_lin = LIN_W'(ofs_row) * LIN_W'(COLUMNS) + LIN_W'(ofs_col);

	// Store port selection: sweep stage or character write, request or sweep read.
	assign mem_we    = wr_s1 || (exec_go && put_we);
	assign mem_waddr = wr_s1 ? addr_s1 : cur_lin[AW-1:0];
	assign mem_wdata = wr_s1 ? (cpy_s1 ? mem_rdata_q : fill_q) : {attr_q, ch_q};
	assign mem_re    = (req_xfer && (op_t'(req.operation) == OP_READ))
		|| ((state_q == S_SWEEP) && sweep_cpy);
	assign mem_raddr = (state_q == S_SWEEP) ? (cnt_q + AW'(COLUMNS)) : rd_lin[AW-1:0];

	// Cell store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// Request latch and sweep write stage payload.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q <= req.operation;
			ch_q <= req.char_code;
			tc_q <= req.target_column;
			tr_q <= req.target_row;
		end
		addr_s1 <= cnt_q;
		cpy_s1  <= sweep_cpy;
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q  <= ofs_col;
			out_row_q  <= ofs_row;
			out_ofs_q  <= ofs_lin[OFS_W-1:0];
			out_cell_q <= (state_q == S_EXEC) ? nxt_cell : '0;
			out_ign_q  <= (state_q == S_EXEC) ? nxt_ign : 1'b0;
		end
	end

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= BLANK_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer: accept, execute, sweep over the store, drain the last write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_SWEEP;
			cur_col_q <= '0;
			cur_row_q <= '0;
			cnt_q     <= '0;
			copy_q    <= 1'b0;
			report_q  <= 1'b0;
			fill_q    <= BLANK_CELL;
			wr_s1     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					wr_s1 <= 1'b0;
					if (req_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					wr_s1 <= 1'b0;
					if (exec_go) begin
						cur_col_q <= nxt_col;
						cur_row_q <= nxt_row;
						if (go_sweep) begin
							state_q  <= S_SWEEP;
							cnt_q    <= '0;
							copy_q   <= !go_clear;
							report_q <= 1'b1;
							fill_q   <= go_clear ? {attr_q, SPACE_CHAR} : BLANK_CELL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SWEEP: begin
					wr_s1 <= 1'b1;
					if (cnt_q == AW'(N - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DRAIN: begin
					wr_s1   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					wr_s1   <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result is only loaded into a free or draining output register.
	`AST_IMP(a_load_slot, load_out, slot_free, "result loaded over a waiting result")
	// The store never reads and writes one entry in the same cycle.
	`AST_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "store read/write clash")
	// An accepted request enters the execute state in the following cycle.
	`AST_NXT(a_accept_exec, req_xfer, state_q == S_EXEC, "accepted request not executed")
	// The cursor always stays on the screen.
	`AST_IMP(a_cursor_range, 1'b1,
		(cur_col_q < COL_W'(COLUMNS - 1) || cur_col_q == COL_W'(COLUMNS - 1))
		&& (cur_row_q < ROW_W'(ROWS - 1) || cur_row_q == ROW_W'(ROWS - 1)),
		"cursor off screen")

endmodule
